/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Invariant that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`endif

/* rtl/core/asc_pkg.sv */
package asc_pkg;

    localparam int CHAR_W            = 21;
    localparam int SHIFT_W           = 12;
    localparam int COUNT_W           = 7;
    localparam int KIND_W            = 2;
    localparam int REG_INDEX_W       = 1;
    localparam int MOD_CNT_W         = $clog2(SHIFT_W + 1);
    localparam int ALPHA_SLOTS_DEF   = 128;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XFORM = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_INDEX_W-1:0] REG_SHIFT     = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_DIRECTION = 1'b1;

    // Direction codes.
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the incoming request and reset the work registers
        logic scan_run;  // step the alphabet scan
        logic mod_run;   // step the shift reduction
        logic idx_calc;  // compute the rotated alphabet position
        logic fetch;     // read the rotated entry
        logic finish;    // commit the request and load the result register
    } asc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              hit;
        logic              scan_done;
        logic              mod_done;
        logic              out_free;
    } asc_status_t;

endpackage

/* rtl/core/asc_ctrl.sv */
module asc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  asc_pkg::asc_status_t status,
    output asc_pkg::asc_cmd_t    cmd
);
    import asc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MOD,
        ST_INDEX,
        ST_FETCH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.kind == KIND_OFFER)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.kind == KIND_XFORM && !status.count_zero)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                priority if (status.hit)
                begin
                    state_next = (status.kind == KIND_OFFER) ? ST_FINISH : ST_MOD;
                end
                else if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_MOD:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_INDEX;
                end
                else
                begin
                    cmd.mod_run = 1'b1;
                end
            end
            ST_INDEX:
            begin
                cmd.idx_calc = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/asc_dp.sv */
module asc_dp #(
    parameter int ALPHA_SLOTS = asc_pkg::ALPHA_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [asc_pkg::REG_INDEX_W-1:0]     cfg_index,
    input  logic [asc_pkg::SHIFT_W-1:0]         cfg_wdata,
    input  logic [asc_pkg::KIND_W-1:0]          kind,
    input  logic [asc_pkg::CHAR_W-1:0]          char_in,
    input  asc_pkg::asc_cmd_t                   cmd,
    output asc_pkg::asc_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [asc_pkg::CHAR_W-1:0]          char_out,
    output logic                                matched,
    output logic                                accepted,
    output logic [asc_pkg::COUNT_W-1:0]         count,
    output logic                                empty_error
);
    import asc_pkg::*;

    localparam int CAPACITY = ALPHA_SLOTS - 1;
    localparam int CNT_W    = $clog2(ALPHA_SLOTS);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W    = CNT_W + 1;

    logic [CHAR_W-1:0]    mem [CAPACITY];

    logic [SHIFT_W-1:0]   shift_amount_reg;
    logic                 direction_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [KIND_W-1:0]    item_kind_reg;
    logic [CHAR_W-1:0]    item_char_reg;

    logic [CNT_W-1:0]     scan_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_pos_reg;
    logic [CHAR_W-1:0]    rd_data_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     pos_reg;

    logic [SHIFT_W-1:0]   mshift_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     tgt_reg;

    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_out_reg;
    logic                 matched_reg;
    logic                 accepted_reg;
    logic [COUNT_W-1:0]   count_out_reg;
    logic                 empty_error_reg;

    logic                 issue;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 hit_now;
    logic                 wr_en;
    logic                 accept_now;
    logic                 match_now;
    logic                 empty_now;
    logic [SUM_W-1:0]     n_ext;
    logic [SUM_W-1:0]     trial;
    logic [SUM_W-1:0]     rem_next;
    logic [SUM_W-1:0]     pos_ext;
    logic [SUM_W-1:0]     s_ext;
    logic [SUM_W-1:0]     t_raw;
    logic [SUM_W-1:0]     t_red;

    // Scan reads one entry a cycle; the compare works on the registered read data, in the cycle after the read.
    assign issue   = cmd.scan_run && (scan_reg != count_reg);
    assign rd_en   = issue || cmd.fetch;
    assign rd_addr = cmd.fetch ? tgt_reg : scan_reg[IDX_W-1:0];
    assign hit_now = rd_vld_reg && (rd_data_reg == item_char_reg);

    // Restoring remainder step, one shift bit a cycle, most significant first.
    assign n_ext    = SUM_W'(count_reg);
    assign trial    = {rem_reg, mshift_reg[SHIFT_W-1]};
    assign rem_next = (trial >= n_ext) ? (trial - n_ext) : trial;

    // Rotated position; both operands are below the count, so one subtract wraps it.
    assign pos_ext = SUM_W'(pos_reg);
    assign s_ext   = SUM_W'(rem_reg);
    assign t_raw   = (direction_reg == DIR_DECRYPT) ? (pos_ext + n_ext - s_ext)
                                                    : (pos_ext + s_ext);
    assign t_red   = (t_raw >= n_ext) ? (t_raw - n_ext) : t_raw;

    assign accept_now = (item_kind_reg == KIND_OFFER) && !hit_reg
                        && (count_reg != CNT_W'(CAPACITY));
    assign match_now  = (item_kind_reg == KIND_XFORM) && hit_reg;
    assign empty_now  = (item_kind_reg == KIND_XFORM) && (count_reg == '0);
    assign wr_en      = cmd.finish && accept_now;

    always_comb
    begin
        count_next = count_reg;
        if (item_kind_reg == KIND_CLEAR)
        begin
            count_next = '0;
        end
        else if (accept_now)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign status.kind       = item_kind_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.hit        = hit_now;
    assign status.scan_done  = (scan_reg == count_reg) && !rd_vld_reg;
    assign status.mod_done   = (mod_cnt_reg == MOD_CNT_W'(SHIFT_W));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= item_char_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_amount_reg <= '0;
            direction_reg    <= DIR_ENCRYPT;
            count_reg        <= '0;
            scan_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            hit_reg          <= 1'b0;
            mod_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SHIFT:     shift_amount_reg <= cfg_wdata;
                    REG_DIRECTION: direction_reg    <= cfg_wdata[0];
                    default:       direction_reg    <= direction_reg;
                endcase
            end

            rd_vld_reg <= issue;
            if (cmd.load)
            begin
                scan_reg    <= '0;
                hit_reg     <= 1'b0;
                mod_cnt_reg <= '0;
            end
            else
            begin
                if (issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cmd.scan_run && hit_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmd.mod_run)
                begin
                    mod_cnt_reg <= mod_cnt_reg + 1'b1;
                end
            end

            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_kind_reg <= kind;
            item_char_reg <= char_in;
            mshift_reg    <= shift_amount_reg;
            rem_reg       <= '0;
        end
        else if (cmd.mod_run)
        begin
            mshift_reg <= {mshift_reg[SHIFT_W-2:0], 1'b0};
            rem_reg    <= rem_next[CNT_W-1:0];
        end
        if (issue)
        begin
            rd_pos_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmd.scan_run && hit_now)
        begin
            pos_reg <= rd_pos_reg;
        end
        if (cmd.idx_calc)
        begin
            tgt_reg <= t_red[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            char_out_reg    <= match_now ? rd_data_reg : item_char_reg;
            matched_reg     <= match_now;
            accepted_reg    <= accept_now;
            count_out_reg   <= COUNT_W'(count_next);
            empty_error_reg <= empty_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign matched     = matched_reg;
    assign accepted    = accepted_reg;
    assign count       = count_out_reg;
    assign empty_error = empty_error_reg;

endmodule

/* rtl/core/alphabet_shift_cipher.sv */
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_ready    kind, char_in
// result    out        out_valid / out_ready  char_out, matched, accepted, count, empty_error
// config    in         cfg_wr_en              cfg_index, cfg_wdata
//
// One request at a time. A clear or an unknown kind goes from acceptance through decode
// to the result register. An offer adds the alphabet scan (one memory read per cycle);
// a transform adds the scan and, on a hit, the 12-step shift reduction, index and fetch.
// Reset returns the alphabet count, the configuration and the controller to zero and idle;
// the alphabet memory itself is not cleared. A new request is taken while the previous
// result still waits; only the final commit stalls until the result register frees up.
module alphabet_shift_cipher #(
    parameter int ALPHA_SLOTS = asc_pkg::ALPHA_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [asc_pkg::REG_INDEX_W-1:0] cfg_index,
    input  logic [asc_pkg::SHIFT_W-1:0]     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [asc_pkg::KIND_W-1:0]      kind,
    input  logic [asc_pkg::CHAR_W-1:0]      char_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [asc_pkg::CHAR_W-1:0]      char_out,
    output logic                            matched,
    output logic                            accepted,
    output logic [asc_pkg::COUNT_W-1:0]     count,
    output logic                            empty_error
);
    import asc_pkg::*;

    asc_cmd_t    cmd;
    asc_status_t status;

    // The controller sequences each request: decode, scan, shift reduction,
    // index calculation, fetch of the rotated entry and the final commit.
    asc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the alphabet memory, the configuration registers,
    // the scan and remainder units and the result register.
    asc_dp #(
        .ALPHA_SLOTS (ALPHA_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .char_in     (char_in),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .matched     (matched),
        .accepted    (accepted),
        .count       (count),
        .empty_error (empty_error)
    );

`include "assert_macros.svh"

    // The controller issues at most one command per cycle.
    `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
    // A request is committed only when the result register can take it.
    `ASSERT_IMPLIES(a_finish_free, clk, rst_n, cmd.finish, status.out_free)
    // In the cycle after a request is taken the block is busy.
    `ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, !in_ready)
    // A matched transform never reports an offer acceptance or an empty alphabet.
    `ASSERT_IMPLIES(a_match_excl, clk, rst_n, out_valid && matched, !accepted && !empty_error)

endmodule
